// ===== sv/doc_pkg.sv =====
// Shared types, constants and helpers of the disparity outlier counter.
package doc_pkg;

    // Saturation bound of every count; counter width follows from it.
    localparam int MAX_PIXELS = 1048576;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int OUT_W      = 21;
    localparam int WIDE_W     = (CNT_W > OUT_W) ? CNT_W : OUT_W;

    localparam int DISP_W     = 16;
    localparam int DIV_W      = 8;
    localparam int PROD_W     = DISP_W + DIV_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REL_DIVISOR   = CFG_IDX_W'(1);
    localparam logic [DISP_W-1:0]    ABS_THRESHOLD_RST = DISP_W'(768);
    localparam logic [DIV_W-1:0]     REL_DIVISOR_RST   = DIV_W'(20);

    // Regions and counter slots inside a region.
    localparam int NUM_REGIONS = 3;
    localparam int NUM_SLOTS   = 4;
    localparam logic [1:0] REGION_BG  = 2'd0;
    localparam logic [1:0] REGION_FG  = 2'd1;
    localparam logic [1:0] REGION_ALL = 2'd2;
    localparam int SLOT_OUT_ALL = 0;
    localparam int SLOT_PIX_ALL = 1;
    localparam int SLOT_OUT_EST = 2;
    localparam int SLOT_PIX_EST = 3;

    // Depth of the queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [OUT_W-1:0]  t_out_cnt;
    typedef logic [WIDE_W-1:0] t_wide_cnt;

    // Classified pixel handed from front to back.
    typedef struct packed {
        logic gt_valid;
        logic foreground;
        logic outlier;
        logic est_valid;
        logic last_pixel;
    } t_pix_rec;

    // Mask a count to the output width.
    function automatic t_out_cnt to_out(input t_cnt c);
        t_wide_cnt w;
        w = t_wide_cnt'(c);
        return w[OUT_W-1:0];
    endfunction

endpackage

// ===== sv/doc_front.sv =====
// Front end: pixel input stage, configuration registers and outlier classification.
module doc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [doc_pkg::DISP_W-1:0]       i_gt_disp,
    input  logic                             i_gt_valid,
    input  logic [doc_pkg::DISP_W-1:0]       i_est_disp,
    input  logic                             i_est_valid,
    input  logic                             i_foreground,
    input  logic                             i_last_pixel,
    input  logic                             i_cfg_we,
    input  logic [doc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [doc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output doc_pkg::t_pix_rec                o_q_rec
);

    logic                           r_vld;
    logic [doc_pkg::DISP_W-1:0]     r_err;
    logic [doc_pkg::DISP_W-1:0]     r_gt;
    logic                           r_gtv;
    logic                           r_est;
    logic                           r_fg;
    logic                           r_last;
    logic [doc_pkg::DISP_W-1:0]     r_thr;
    logic [doc_pkg::DIV_W-1:0]      r_div;

    logic                           keep;
    logic                           stall;
    logic                           accept;
    logic [doc_pkg::PROD_W-1:0]     prod;

    // Pixels without ground truth that do not close the frame change nothing: drop them.
    assign keep   = r_gtv || r_last;
    assign stall  = r_vld && keep && i_q_full;
    assign o_full = stall;
    assign accept = i_push && !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_thr <= doc_pkg::ABS_THRESHOLD_RST;
            r_div <= doc_pkg::REL_DIVISOR_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    doc_pkg::CFG_ABS_THRESHOLD: r_thr <= i_cfg_data;
                    doc_pkg::CFG_REL_DIVISOR:   r_div <= i_cfg_data[doc_pkg::DIV_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_vld <= 1'b1;
            end else if (!stall) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err  <= (i_gt_disp > i_est_disp) ? (i_gt_disp - i_est_disp)
                                               : (i_est_disp - i_gt_disp);
            r_gt   <= i_gt_disp;
            r_gtv  <= i_gt_valid;
            r_est  <= i_est_valid;
            r_fg   <= i_foreground;
            r_last <= i_last_pixel;
        end
    end

    assign prod = doc_pkg::PROD_W'(r_err) * doc_pkg::PROD_W'(r_div);

    always_comb begin
        o_q_push           = r_vld && keep;
        o_q_rec.gt_valid   = r_gtv;
        o_q_rec.foreground = r_fg;
        o_q_rec.outlier    = (r_err > r_thr) && (prod > doc_pkg::PROD_W'(r_gt));
        o_q_rec.est_valid  = r_est;
        o_q_rec.last_pixel = r_last;
    end

endmodule

// ===== sv/doc_fifo.sv =====
// Short queue of classified pixels between front and back.
module doc_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  doc_pkg::t_pix_rec    i_rec,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output doc_pkg::t_pix_rec    o_rec
);

    doc_pkg::t_pix_rec                 r_mem [doc_pkg::FIFO_DEPTH];
    logic [doc_pkg::FIFO_PTR_W-1:0]    r_wptr;
    logic [doc_pkg::FIFO_PTR_W-1:0]    r_rptr;
    logic [doc_pkg::FIFO_CNT_W-1:0]    r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == doc_pkg::FIFO_CNT_W'(doc_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

endmodule

// ===== sv/doc_back.sv =====
// Back end: saturating region counters and the per-frame result buffer.
module doc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  doc_pkg::t_pix_rec             i_q_rec,
    output logic                          o_q_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [1:0]                    o_region,
    output logic [doc_pkg::OUT_W-1:0]     o_outliers_all,
    output logic [doc_pkg::OUT_W-1:0]     o_pixels_all,
    output logic [doc_pkg::OUT_W-1:0]     o_outliers_est,
    output logic [doc_pkg::OUT_W-1:0]     o_pixels_est,
    output logic                          o_final_region
);

    doc_pkg::t_cnt r_cnt  [doc_pkg::NUM_REGIONS][doc_pkg::NUM_SLOTS];
    doc_pkg::t_cnt n_cnt  [doc_pkg::NUM_REGIONS][doc_pkg::NUM_SLOTS];
    doc_pkg::t_cnt r_snap [doc_pkg::NUM_REGIONS][doc_pkg::NUM_SLOTS];
    logic [1:0]    r_left;

    logic snap_free;
    logic do_pop;
    logic load;

    assign do_pop    = i_pop && (r_left != 2'd0);
    assign snap_free = (r_left == 2'd0) || ((r_left == 2'd1) && i_pop);
    assign o_q_pop   = !i_q_empty && (!i_q_rec.last_pixel || snap_free);
    assign load      = o_q_pop && i_q_rec.last_pixel;

    // Bump each counter whose region and slot the pixel hits; hold at the bound.
    always_comb begin
        logic hit;
        logic inc;
        for (int r = 0; r < doc_pkg::NUM_REGIONS; r++) begin
            hit = (r == int'(doc_pkg::REGION_ALL)) || (r == int'(i_q_rec.foreground));
            for (int k = 0; k < doc_pkg::NUM_SLOTS; k++) begin
                unique case (k)
                    doc_pkg::SLOT_OUT_ALL: inc = i_q_rec.outlier;
                    doc_pkg::SLOT_PIX_ALL: inc = 1'b1;
                    doc_pkg::SLOT_OUT_EST: inc = i_q_rec.outlier && i_q_rec.est_valid;
                    default:               inc = i_q_rec.est_valid;
                endcase
                n_cnt[r][k] = r_cnt[r][k];
                if (o_q_pop && i_q_rec.gt_valid && hit && inc &&
                    (r_cnt[r][k] < doc_pkg::CNT_W'(doc_pkg::MAX_PIXELS))) begin
                    n_cnt[r][k] = r_cnt[r][k] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
            for (int r = 0; r < doc_pkg::NUM_REGIONS; r++) begin
                for (int k = 0; k < doc_pkg::NUM_SLOTS; k++) begin
                    r_cnt[r][k] <= '0;
                end
            end
        end else begin
            for (int r = 0; r < doc_pkg::NUM_REGIONS; r++) begin
                for (int k = 0; k < doc_pkg::NUM_SLOTS; k++) begin
                    r_cnt[r][k] <= load ? '0 : n_cnt[r][k];
                end
            end
            if (load) begin
                r_left <= 2'(doc_pkg::NUM_REGIONS);
            end else if (do_pop) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    // Capture the closing counts, then advance one region per result transaction.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_snap <= n_cnt;
        end else if (do_pop) begin
            for (int r = 0; r < doc_pkg::NUM_REGIONS - 1; r++) begin
                r_snap[r] <= r_snap[r + 1];
            end
        end
    end

    assign o_empty        = (r_left == 2'd0);
    assign o_region       = 2'(doc_pkg::NUM_REGIONS) - r_left;
    assign o_final_region = (o_region == doc_pkg::REGION_ALL);
    assign o_outliers_all = doc_pkg::to_out(r_snap[0][doc_pkg::SLOT_OUT_ALL]);
    assign o_pixels_all   = doc_pkg::to_out(r_snap[0][doc_pkg::SLOT_PIX_ALL]);
    assign o_outliers_est = doc_pkg::to_out(r_snap[0][doc_pkg::SLOT_OUT_EST]);
    assign o_pixels_est   = doc_pkg::to_out(r_snap[0][doc_pkg::SLOT_PIX_EST]);

endmodule

// ===== sv/disparity_outlier_counter.sv =====
// Top level of the disparity outlier counter: front end, pixel queue and back end.
// Throughput: one pixel per cycle while full is low; a closing pixel waits in the
//   queue until the previous frame's three results are taken, since the back end
//   holds one result set. Results: the first of a frame shows once its last pixel has
//   passed the front register, the queue and the snapshot; the next two follow per pop.
// Reset (synchronous, active low): counters and queue clear, thresholds return to
//   3.0 px absolute and a divisor of 20; no result is pending.
module disparity_outlier_counter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel side
    input  logic                            push,
    output logic                            full,
    input  logic [doc_pkg::DISP_W-1:0]      i_gt_disp,
    input  logic                            i_gt_valid,
    input  logic [doc_pkg::DISP_W-1:0]      i_est_disp,
    input  logic                            i_est_valid,
    input  logic                            i_foreground,
    input  logic                            i_last_pixel,
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [doc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [doc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Result side
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      o_region,
    output logic [doc_pkg::OUT_W-1:0]       o_outliers_all,
    output logic [doc_pkg::OUT_W-1:0]       o_pixels_all,
    output logic [doc_pkg::OUT_W-1:0]       o_outliers_est,
    output logic [doc_pkg::OUT_W-1:0]       o_pixels_est,
    output logic                            o_final_region
);

    // Classified pixels flow front -> queue -> back.
    logic              f_push;
    doc_pkg::t_pix_rec f_rec;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    doc_pkg::t_pix_rec q_rec;

    // Register the pixel with its absolute error, then run the threshold and
    // relative tests on the way into the queue.
    doc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_gt_disp    (i_gt_disp),
        .i_gt_valid   (i_gt_valid),
        .i_est_disp   (i_est_disp),
        .i_est_valid  (i_est_valid),
        .i_foreground (i_foreground),
        .i_last_pixel (i_last_pixel),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_q_push     (f_push),
        .o_q_rec      (f_rec)
    );

    // Decouple the classifier from the counters so either side can stall alone.
    doc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_rec   (f_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rec   (q_rec)
    );

    // Count into the background or foreground region and the all-pixel region;
    // on the closing pixel, snapshot the counts for readout and clear them.
    doc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_rec        (q_rec),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_region       (o_region),
        .o_outliers_all (o_outliers_all),
        .o_pixels_all   (o_pixels_all),
        .o_outliers_est (o_outliers_est),
        .o_pixels_est   (o_pixels_est),
        .o_final_region (o_final_region)
    );

endmodule
